// ----- design/dlfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dollar-length frame receiver.
// No dependencies; used by dollar_length_frame_receiver_core.
package dlfr_pkg;

  // receiver phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TIMEOUT   = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_TXXX  = 3'd1,
    CLS_DWXX  = 3'd2,
    CLS_FKXX  = 3'd3,
    CLS_ICXX  = 3'd4,
    CLS_SJXX  = 3'd5
  } cmd_class_e;

  // configuration register indexes
  localparam logic CFG_RX_ENABLE    = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  HDR_CHAR        = 8'h24;  // '$'
  localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
  localparam logic [15:0] MIN_FRAME_LEN   = 16'd8;
  localparam logic [31:0] CMD_TXXX        = 32'h5458_5858;
  localparam logic [31:0] CMD_DWXX        = 32'h4457_5858;
  localparam logic [31:0] CMD_FKXX        = 32'h464B_5858;
  localparam logic [31:0] CMD_ICXX        = 32'h4943_5858;
  localparam logic [31:0] CMD_SJXX        = 32'h534A_5858;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] frame_byte;
    logic [9:0] byte_index;
    logic       last;
    cmd_class_e cmd_class;
  } result_t;

  function automatic cmd_class_e classify(input logic [31:0] letters);
    cmd_class_e cls;
    cls = CLS_OTHER;
    if (letters == CMD_TXXX) cls = CLS_TXXX;
    if (letters == CMD_DWXX) cls = CLS_DWXX;
    if (letters == CMD_FKXX) cls = CLS_FKXX;
    if (letters == CMD_ICXX) cls = CLS_ICXX;
    if (letters == CMD_SJXX) cls = CLS_SJXX;
    return cls;
  endfunction

endpackage

// ----- design/dollar_length_frame_receiver_core.sv -----
`timescale 1ns / 1ps
// Frame receiver for '$'-headed messages with a big-endian length field.
// Depends on dlfr_pkg.
//
// Usage:
//  - Input stream (s_axis_*): one item per received byte or timer tick.
//    tuser[0] = 1 marks a tick; tdata carries the received byte.
//  - Output stream (m_axis_*): one item per frame byte, timeout drop or
//    malformed-length drop. tuser gives the kind, tlast marks the final
//    byte of a complete frame, which also carries the command class.
//  - Config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//    (0 rx_enable, 1 timeout_ticks). Write only while the block is idle.
//  - Throughput: one item per cycle while s_axis_tready is high. A result
//    is registered in the output (or skid) register; the per-byte state
//    update is combinational between the input handshake and that register.
//  - Backpressure: a two-entry output stage (output register plus skid
//    register) lets one more item in while a result waits; s_axis_tready
//    drops only when both entries are full.
//  - Reset: hunting for '$', rx_enable = 1, timeout_ticks = 500, no
//    results pending.
module dollar_length_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_LEN = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] frame_byte, [17:8] byte_index,
                                      // [20:18] command_class, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_LEN + 1);

  // configuration
  logic        rx_enable_q;
  logic [15:0] timeout_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q     <= 1'b1;
      timeout_ticks_q <= dlfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dlfr_pkg::CFG_RX_ENABLE:     rx_enable_q     <= cfg_wdata_i[0];
        dlfr_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // receiver state
  dlfr_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  byte_count_q, byte_count_d;
  logic [15:0]      expected_length_q, expected_length_d;
  logic [31:0]      command_letters_q, command_letters_d;
  logic [15:0]      idle_ticks_q, idle_ticks_d;

  logic             in_accept;
  logic             is_tick;
  logic [7:0]       rx_byte;
  logic             res_valid;
  dlfr_pkg::result_t res;

  logic [CntW-1:0]  cnt_inc;
  logic [15:0]      idle_inc;
  logic [15:0]      limit;
  logic [15:0]      len_full;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign is_tick   = s_axis_tuser[0];
  assign rx_byte   = s_axis_tdata;
  assign cnt_inc   = byte_count_q + CntW'(1);
  assign idle_inc  = (idle_ticks_q == 16'hFFFF) ? idle_ticks_q : idle_ticks_q + 16'd1;
  assign limit     = (timeout_ticks_q == 16'd0) ? 16'd1 : timeout_ticks_q;
  assign len_full  = {expected_length_q[15:8], rx_byte};

  always_comb begin
    phase_d           = phase_q;
    byte_count_d      = byte_count_q;
    expected_length_d = expected_length_q;
    command_letters_d = command_letters_q;
    idle_ticks_d      = idle_ticks_q;
    res_valid         = 1'b0;
    res.kind          = dlfr_pkg::KIND_BYTE;
    res.frame_byte    = rx_byte;
    res.byte_index    = 10'(byte_count_q);
    res.last          = 1'b0;
    res.cmd_class     = dlfr_pkg::CLS_OTHER;

    if (in_accept && rx_enable_q) begin
      if (is_tick) begin
        if (phase_q != dlfr_pkg::PH_HUNT) begin
          idle_ticks_d = idle_inc;
          if (idle_inc >= limit) begin
            phase_d           = dlfr_pkg::PH_HUNT;
            byte_count_d      = '0;
            expected_length_d = '0;
            idle_ticks_d      = '0;
            res_valid         = 1'b1;
            res.kind          = dlfr_pkg::KIND_TIMEOUT;
            res.frame_byte    = '0;
            res.byte_index    = '0;
          end
        end
      end else begin
        unique case (phase_q)
          dlfr_pkg::PH_HUNT: begin
            if (rx_byte == dlfr_pkg::HDR_CHAR) begin
              phase_d        = dlfr_pkg::PH_CMD;
              byte_count_d   = CntW'(1);
              idle_ticks_d   = '0;
              res_valid      = 1'b1;
              res.byte_index = '0;
            end
          end
          dlfr_pkg::PH_CMD: begin
            idle_ticks_d      = '0;
            command_letters_d = {command_letters_q[23:0], rx_byte};
            byte_count_d      = cnt_inc;
            if (cnt_inc >= CntW'(5)) phase_d = dlfr_pkg::PH_LEN;
            res_valid         = 1'b1;
          end
          dlfr_pkg::PH_LEN: begin
            idle_ticks_d = '0;
            res_valid    = 1'b1;
            if (byte_count_q == CntW'(5)) begin
              expected_length_d = {rx_byte, 8'h00};
              byte_count_d      = cnt_inc;
            end else if (len_full < dlfr_pkg::MIN_FRAME_LEN ||
                         17'(len_full) > 17'(MAX_FRAME_LEN)) begin
              phase_d           = dlfr_pkg::PH_HUNT;
              byte_count_d      = '0;
              expected_length_d = '0;
              res.kind          = dlfr_pkg::KIND_MALFORMED;
              res.frame_byte    = '0;
              res.byte_index    = '0;
            end else begin
              expected_length_d = len_full;
              byte_count_d      = cnt_inc;
              phase_d           = dlfr_pkg::PH_BODY;
            end
          end
          dlfr_pkg::PH_BODY: begin
            idle_ticks_d = '0;
            res_valid    = 1'b1;
            byte_count_d = cnt_inc;
            if (17'(cnt_inc) >= 17'(expected_length_q)) begin
              phase_d           = dlfr_pkg::PH_HUNT;
              byte_count_d      = '0;
              expected_length_d = '0;
              res.last          = 1'b1;
              res.cmd_class     = dlfr_pkg::classify(command_letters_q);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= dlfr_pkg::PH_HUNT;
      byte_count_q      <= '0;
      expected_length_q <= '0;
      command_letters_q <= '0;
      idle_ticks_q      <= '0;
    end else begin
      phase_q           <= phase_d;
      byte_count_q      <= byte_count_d;
      expected_length_q <= expected_length_d;
      command_letters_q <= command_letters_d;
      idle_ticks_q      <= idle_ticks_d;
    end
  end

  // output register plus skid register
  logic              out_valid_q, skid_valid_q;
  dlfr_pkg::result_t out_q, skid_q;
  logic              out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // skid is only full when no new item was accepted this cycle
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.cmd_class, out_q.byte_index, out_q.frame_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_idle_only_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_ticks_q != 16'd0 |-> phase_q != dlfr_pkg::PH_HUNT)
    else $error("idle tick count nonzero while hunting");

  a_body_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dlfr_pkg::PH_BODY |->
      expected_length_q >= dlfr_pkg::MIN_FRAME_LEN &&
      17'(expected_length_q) <= 17'(MAX_FRAME_LEN))
    else $error("body phase with out-of-range frame length");

  a_body_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dlfr_pkg::PH_BODY |-> 17'(byte_count_q) < 17'(expected_length_q))
    else $error("body byte count reached frame length without closing frame");

  a_noise_keeps_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_tick && phase_q == dlfr_pkg::PH_HUNT &&
      rx_byte != dlfr_pkg::HDR_CHAR |-> !res_valid ##1 phase_q == dlfr_pkg::PH_HUNT)
    else $error("noise byte left hunt phase");
`endif

endmodule

// ----- bench/dollar_length_frame_receiver_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for dollar_length_frame_receiver_core: directed and random byte/tick
// streams, an item-level predictor of the framing state and a per-field result check.
// Depends on dlfr_pkg and the core RTL only.
module dollar_length_frame_receiver_core_tb;

  localparam int unsigned MAX_LEN     = 1024;
  localparam int          HOLD_CYCLES = 300;
  // about 1050 items, each slowed by input gaps and output stalls, plus the long hold
  localparam int          CYCLE_LIMIT = 40_000;
  localparam logic        REQ_BYTE    = 1'b0;
  localparam logic        REQ_TICK    = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] frame_byte, [17:8] byte_index, [20:18] command_class
  logic [1:0]  m_axis_tuser;   // [1:0] out_kind
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_wdata_i;

  dollar_length_frame_receiver_core #(
    .MAX_FRAME_LEN(MAX_LEN)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // framing state mirror
  logic              rx_en;
  logic [15:0]       tmo;
  dlfr_pkg::phase_e  ph;
  logic [10:0]       cnt;
  logic [15:0]       exp_len;
  logic [15:0]       idle_cnt;
  logic [31:0]       letters;
  dlfr_pkg::result_t pending_results[$];

  int  items_sent;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;
  int  err_cnt;
  int  cycle_cnt;
  int  n_frames, n_timeouts, n_malformed, n_bytes;

  function automatic void restart_hunt();
    ph       = dlfr_pkg::PH_HUNT;
    cnt      = '0;
    exp_len  = '0;
    idle_cnt = '0;
  endfunction

  function automatic dlfr_pkg::cmd_class_e class_of(input logic [31:0] l);
    case (l)
      dlfr_pkg::CMD_TXXX: return dlfr_pkg::CLS_TXXX;
      dlfr_pkg::CMD_DWXX: return dlfr_pkg::CLS_DWXX;
      dlfr_pkg::CMD_FKXX: return dlfr_pkg::CLS_FKXX;
      dlfr_pkg::CMD_ICXX: return dlfr_pkg::CLS_ICXX;
      dlfr_pkg::CMD_SJXX: return dlfr_pkg::CLS_SJXX;
      default:            return dlfr_pkg::CLS_OTHER;
    endcase
  endfunction

  // work out the result (if any) of one accepted item and queue it
  function automatic void predict_frame_result(input logic tick, input logic [7:0] b);
    dlfr_pkg::result_t r;
    logic [15:0]       lim;
    logic [15:0]       len_now;
    r = '0;
    if (!rx_en) return;
    if (tick == REQ_TICK) begin
      if (ph == dlfr_pkg::PH_HUNT) return;
      if (idle_cnt != 16'hFFFF) idle_cnt++;
      lim = (tmo == 16'd0) ? 16'd1 : tmo;
      if (idle_cnt >= lim) begin
        restart_hunt();
        r.kind = dlfr_pkg::KIND_TIMEOUT;
        pending_results.push_back(r);
      end
      return;
    end
    if (ph == dlfr_pkg::PH_HUNT) begin
      if (b != dlfr_pkg::HDR_CHAR) return;
      ph       = dlfr_pkg::PH_CMD;
      cnt      = 11'd1;
      idle_cnt = '0;
      r.kind       = dlfr_pkg::KIND_BYTE;
      r.frame_byte = b;
      pending_results.push_back(r);
      return;
    end
    idle_cnt     = '0;
    r.kind       = dlfr_pkg::KIND_BYTE;
    r.frame_byte = b;
    r.byte_index = cnt[9:0];
    case (ph)
      dlfr_pkg::PH_CMD: begin
        letters = {letters[23:0], b};
        cnt++;
        if (cnt >= 11'd5) ph = dlfr_pkg::PH_LEN;
      end
      dlfr_pkg::PH_LEN: begin
        if (cnt == 11'd5) begin
          exp_len = {b, 8'h00};
          cnt++;
        end else begin
          len_now = {exp_len[15:8], b};
          if (len_now < dlfr_pkg::MIN_FRAME_LEN || len_now > MAX_LEN) begin
            restart_hunt();
            r      = '0;
            r.kind = dlfr_pkg::KIND_MALFORMED;
          end else begin
            exp_len = len_now;
            cnt++;
            ph = dlfr_pkg::PH_BODY;
          end
        end
      end
      default: begin
        cnt++;
        if (cnt >= exp_len) begin
          r.last      = 1'b1;
          r.cmd_class = class_of(letters);
          restart_hunt();
        end
      end
    endcase
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_item(input logic tick, input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      // one burst in five is long, so there are stretches with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= tick;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame_result(tick, b);
    items_sent++;
  endtask

  task automatic maybe_ticks(input int pct);
    int n;
    if ($urandom_range(0, 99) >= pct) return;
    n = $urandom_range(1, 3);
    repeat (n) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_header(input logic [31:0] l, input logic [15:0] len, input int tick_pct);
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    for (int i = 3; i >= 0; i--) begin
      maybe_ticks(tick_pct);
      send_item(REQ_BYTE, l[8*i +: 8]);
    end
    maybe_ticks(tick_pct);
    send_item(REQ_BYTE, len[15:8]);
    maybe_ticks(tick_pct);
    send_item(REQ_BYTE, len[7:0]);
  endtask

  task automatic send_body(input int n, input int tick_pct);
    for (int i = 0; i < n; i++) begin
      maybe_ticks(tick_pct);
      send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == dlfr_pkg::CFG_RX_ENABLE) rx_en = val[0];
    else tmo = val;
  endtask

  function automatic logic [31:0] pick_letters();
    logic [31:0] l;
    case ($urandom_range(0, 6))
      0: l = dlfr_pkg::CMD_TXXX;
      1: l = dlfr_pkg::CMD_DWXX;
      2: l = dlfr_pkg::CMD_FKXX;
      3: l = dlfr_pkg::CMD_ICXX;
      4: l = dlfr_pkg::CMD_SJXX;
      5: l = $urandom;
      default: begin
        // near miss: one letter of a known command replaced
        l = dlfr_pkg::CMD_SJXX;
        l[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
      end
    endcase
    return l;
  endfunction

  // ---------------------------------------------------------------- output side
  initial begin : sink
    int pat_cnt;
    int stall_mode;
    pat_cnt    = 0;
    stall_mode = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk_i);
      end else begin
        pat_cnt++;
        if (pat_cnt % 128 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (pat_cnt % 5) < 3;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: kind %0d data %h", m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        dlfr_pkg::result_t want;
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("out_kind expected %0d got %0d", want.kind, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[7:0] !== want.frame_byte) begin
          $error("frame_byte expected %0d got %0d", want.frame_byte, m_axis_tdata[7:0]);
          err_cnt++;
        end
        if (m_axis_tdata[17:8] !== want.byte_index) begin
          $error("byte_index expected %0d got %0d", want.byte_index, m_axis_tdata[17:8]);
          err_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %0d got %0d", want.last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tdata[20:18] !== want.cmd_class) begin
          $error("command_class expected %0d got %0d", want.cmd_class, m_axis_tdata[20:18]);
          err_cnt++;
        end
      end
      case (m_axis_tuser)
        dlfr_pkg::KIND_TIMEOUT:   n_timeouts++;
        dlfr_pkg::KIND_MALFORMED: n_malformed++;
        default: begin
          n_bytes++;
          if (m_axis_tlast) n_frames++;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_noise_while_hunting();
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, 8'h23);
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_TICK, 8'h00);
  endtask

  task automatic test_min_frame();
    send_header(dlfr_pkg::CMD_TXXX, 16'd8, 0);
    send_item(REQ_BYTE, 8'hFF);
  endtask

  task automatic test_malformed_bounds();
    send_header(dlfr_pkg::CMD_DWXX, 16'd7, 0);
    send_header(dlfr_pkg::CMD_DWXX, 16'(MAX_LEN + 1), 0);
  endtask

  // reset timeout of 500: tick 499 keeps the frame, tick 500 drops it
  task automatic test_default_timeout();
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    repeat (500) send_item(REQ_TICK, 8'h00);
    drain();
  endtask

  // smallest timeout: one tick drops the frame in every phase
  task automatic test_timeout_one();
    write_reg(dlfr_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    send_item(REQ_BYTE, 8'h46);
    send_item(REQ_BYTE, 8'h4B);
    send_item(REQ_BYTE, 8'h58);
    send_item(REQ_BYTE, 8'h58);
    send_item(REQ_TICK, 8'h00);
    send_header(dlfr_pkg::CMD_ICXX, 16'd9, 0);
    send_item(REQ_BYTE, 8'h61);
    send_item(REQ_TICK, 8'h00);
    drain();
  endtask

  // disabled block must hold its partial frame, idle count included
  task automatic test_disable_hold();
    write_reg(dlfr_pkg::CFG_TIMEOUT_TICKS, 16'd20);
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    send_item(REQ_BYTE, 8'h53);
    send_item(REQ_BYTE, 8'h4A);
    drain();
    write_reg(dlfr_pkg::CFG_RX_ENABLE, 16'd0);
    send_item(REQ_BYTE, dlfr_pkg::HDR_CHAR);
    send_item(REQ_BYTE, 8'hFF);
    repeat (30) send_item(REQ_TICK, 8'h00);
    drain();
    write_reg(dlfr_pkg::CFG_RX_ENABLE, 16'd1);
    send_item(REQ_BYTE, 8'h58);
    send_item(REQ_BYTE, 8'h58);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'h08);
    send_item(REQ_BYTE, 8'h5A);
    drain();
  endtask

  // largest legal length is taken as a frame, then the partial frame times out
  task automatic test_max_frame();
    send_header(dlfr_pkg::CMD_ICXX, 16'(MAX_LEN), 0);
    send_body(5, 0);
    repeat (tmo) send_item(REQ_TICK, 8'h00);
    drain();
  endtask

  // long output hold-off while the sender keeps pushing a frame
  task automatic test_output_hold();
    hold_req = 1'b1;
    send_header(dlfr_pkg::CMD_FKXX, 16'd40, 0);
    send_body(33, 0);
    drain();
  endtask

  task automatic test_random_traffic(input int n_items, input logic [15:0] tmo_val);
    int          start;
    int          sel;
    logic [15:0] len;
    start = items_sent;
    write_reg(dlfr_pkg::CFG_TIMEOUT_TICKS, tmo_val);
    while (items_sent - start < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        len = (sel < 4) ? 16'($urandom_range(8, 300)) : 16'($urandom_range(8, 40));
        send_header(pick_letters(), len, 10);
        send_body(int'(len) - 7, 10);
      end else if (sel < 80) begin
        len = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7))
                                          : 16'($urandom_range(MAX_LEN + 1, 65535));
        send_header(pick_letters(), len, 0);
      end else if (sel < 90) begin
        // truncated frame left to time out
        len = 16'($urandom_range(8, 40));
        send_header(pick_letters(), len, 0);
        send_body(int'($urandom_range(0, int'(len) - 8)), 0);
        repeat (tmo) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= 1'b0;
    cfg_wdata_i   <= '0;
    rx_en       = 1'b1;
    tmo         = dlfr_pkg::TIMEOUT_RESET;
    letters     = '0;
    restart_hunt();
    items_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    n_frames    = 0;
    n_timeouts  = 0;
    n_malformed = 0;
    n_bytes     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_noise_while_hunting();
    test_min_frame();
    test_malformed_bounds();
    test_default_timeout();
    test_timeout_one();
    test_disable_hold();
    test_max_frame();
    test_output_hold();
    test_random_traffic(130, 16'd1);
    test_random_traffic(130, 16'd6);
    test_random_traffic(130, 16'($urandom_range(20, 60)));

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items: %0d frames complete, %0d frame bytes out",
             items_sent, n_frames, n_bytes);
    $display("drops: %0d by timeout, %0d malformed; %0d mismatches",
             n_timeouts, n_malformed, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
